// ===== rtl/core/fsrd_pkg.sv =====
// shared types, constants and helper functions of the flow source rate detector
package fsrd_pkg;

   localparam int MAX_FLOWS        = 16;
   localparam int SOURCES_PER_FLOW = 8;
   localparam int KEY_BITS         = 64;

   localparam int NSLOTS     = MAX_FLOWS * SOURCES_PER_FLOW;
   localparam int FLOW_IDX_W = (MAX_FLOWS > 1) ? $clog2(MAX_FLOWS) : 1;
   localparam int SRC_IDX_W  = (SOURCES_PER_FLOW > 1) ? $clog2(SOURCES_PER_FLOW) : 1;
   localparam int SLOT_IDX_W = (NSLOTS > 1) ? $clog2(NSLOTS) : 1;
   localparam int SCAN_MAX   = (MAX_FLOWS > SOURCES_PER_FLOW) ? MAX_FLOWS : SOURCES_PER_FLOW;
   localparam int SCAN_IDX_W = (SCAN_MAX > 1) ? $clog2(SCAN_MAX) : 1;
   localparam int SCAN_CNT_W = $clog2(SCAN_MAX + 1);

   localparam int FIELD_KEY_W = 64;
   localparam int ADDR_W      = 32;
   localparam int TIME_W      = 32;
   localparam int COUNT_W     = 16;
   localparam int WINDOW_W    = 16;
   localparam int SRC_THR_W   = 16;
   localparam int FLOW_THR_W  = 19;
   localparam int KIND_W      = 2;
   localparam int SUM_W       = COUNT_W + $clog2(SOURCES_PER_FLOW + 1);
   localparam int CMP_W       = (SUM_W > FLOW_THR_W) ? SUM_W : FLOW_THR_W;

   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 32;

   localparam logic [CSR_INDEX_W-1:0] CSR_WINDOW     = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SOURCE_THR = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_FLOW_THR   = 2'd2;

   localparam logic [KIND_W-1:0] KIND_NONE   = 2'd0;
   localparam logic [KIND_W-1:0] KIND_SOURCE = 2'd1;
   localparam logic [KIND_W-1:0] KIND_FLOW   = 2'd2;

   localparam logic [WINDOW_W-1:0]   WINDOW_RESET     = 16'd10;
   localparam logic [SRC_THR_W-1:0]  SOURCE_THR_RESET = 16'd100;
   localparam logic [FLOW_THR_W-1:0] FLOW_THR_RESET   = 19'd500;

   localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

   typedef struct packed {
      logic [FIELD_KEY_W-1:0] flow_key;
      logic [ADDR_W-1:0]      source_address;
      logic [TIME_W-1:0]      now_seconds;
   } in_word_type;

   typedef struct packed {
      logic [KIND_W-1:0] request_kind;
      logic [ADDR_W-1:0] request_address;
      logic              table_full;
   } out_word_type;

   typedef struct packed {
      logic [WINDOW_W-1:0]   window_seconds;
      logic [SRC_THR_W-1:0]  source_threshold;
      logic [FLOW_THR_W-1:0] flow_sum_limit;
   } cfg_type;

   typedef struct packed {
      logic [ADDR_W-1:0]  address;
      logic [COUNT_W-1:0] count;
      logic [TIME_W-1:0]  start;
   } slot_entry_type;

   typedef struct packed {
      logic                  rd_en;
      logic [FLOW_IDX_W-1:0] rd_idx;
      logic                  wr_en;
      logic [FLOW_IDX_W-1:0] wr_idx;
      logic [KEY_BITS-1:0]   wr_key;
   } flow_cmd_type;

   typedef struct packed {
      logic                used;
      logic [KEY_BITS-1:0] key;
   } flow_rd_type;

   typedef struct packed {
      logic                  rd_en;
      logic [SLOT_IDX_W-1:0] rd_idx;
      logic                  wr_en;
      logic [SLOT_IDX_W-1:0] wr_idx;
      slot_entry_type        wr_data;
      logic                  set_used;
      logic                  init_row;
      logic [FLOW_IDX_W-1:0] row;
   } slot_cmd_type;

   typedef struct packed {
      logic           used;
      slot_entry_type entry;
   } slot_rd_type;

   function automatic logic [SLOT_IDX_W-1:0] slot_index(logic [FLOW_IDX_W-1:0] flow,
                                                         logic [SRC_IDX_W-1:0] src);
      slot_index = SLOT_IDX_W'(SLOT_IDX_W'(flow) * SLOT_IDX_W'(SOURCES_PER_FLOW))
                   + SLOT_IDX_W'(src);
   endfunction

   // window over when start + window < now, no wrap
   function automatic logic expired(logic [TIME_W-1:0] start, logic [TIME_W-1:0] now,
                                    logic [WINDOW_W-1:0] window);
      expired = ({1'b0, start} + (TIME_W + 1)'(window)) < {1'b0, now};
   endfunction

endpackage

// ===== rtl/core/fsrd_flow_mem.sv =====
// flow key memory with per-flow used bits
module fsrd_flow_mem (
   input  logic                  clock,
   input  logic                  reset,
   input  fsrd_pkg::flow_cmd_type cmd,
   output fsrd_pkg::flow_rd_type  rd
);
   import fsrd_pkg::*;

   logic [KEY_BITS-1:0]  flow_key_mem [MAX_FLOWS];
   logic [MAX_FLOWS-1:0] used_ff;
   logic                 rd_used_ff;
   logic [KEY_BITS-1:0]  rd_key_ff;

   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         flow_key_mem[cmd.wr_idx] <= cmd.wr_key;
      end
      if (cmd.rd_en) begin
         rd_key_ff  <= flow_key_mem[cmd.rd_idx];
         rd_used_ff <= used_ff[cmd.rd_idx];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff <= '0;
      end else if (cmd.wr_en) begin
         used_ff[cmd.wr_idx] <= 1'b1;
      end
   end

   assign rd.used = rd_used_ff;
   assign rd.key  = rd_key_ff;

endmodule

// ===== rtl/core/fsrd_slot_mem.sv =====
// source slot memory (address, count, window start) with per-slot used bits
module fsrd_slot_mem (
   input  logic                  clock,
   input  logic                  reset,
   input  fsrd_pkg::slot_cmd_type cmd,
   output fsrd_pkg::slot_rd_type  rd
);
   import fsrd_pkg::*;

   slot_entry_type    slot_mem [NSLOTS];
   logic [NSLOTS-1:0] used_ff;
   logic              rd_used_ff;
   slot_entry_type    rd_entry_ff;

   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         slot_mem[cmd.wr_idx] <= cmd.wr_data;
      end
      if (cmd.rd_en) begin
         rd_entry_ff <= slot_mem[cmd.rd_idx];
         rd_used_ff  <= used_ff[cmd.rd_idx];
      end
   end

   // a new flow clears its row, then its first slot is marked below
   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff <= '0;
      end else begin
         if (cmd.init_row) begin
            for (int s = 0; s < SOURCES_PER_FLOW; s++) begin
               used_ff[slot_index(cmd.row, SRC_IDX_W'(s))] <= 1'b0;
            end
         end
         if (cmd.wr_en && cmd.set_used) begin
            used_ff[cmd.wr_idx] <= 1'b1;
         end
      end
   end

   assign rd.used  = rd_used_ff;
   assign rd.entry = rd_entry_ff;

endmodule

// ===== rtl/core/fsrd_ctrl.sv =====
// sequencer: flow scan, source scan, slot update, new source and new flow writes, and flow sum pass
module fsrd_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  fsrd_pkg::cfg_type      cfg,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  fsrd_pkg::in_word_type  req_word,
   output logic                  res_valid,
   input  logic                  res_ready,
   output fsrd_pkg::out_word_type res_word,
   output fsrd_pkg::flow_cmd_type flow_cmd,
   input  fsrd_pkg::flow_rd_type  flow_rd,
   output fsrd_pkg::slot_cmd_type slot_cmd,
   input  fsrd_pkg::slot_rd_type  slot_rd
);
   import fsrd_pkg::*;

   typedef enum logic [7:0] {
      ST_IDLE    = 8'b0000_0001,
      ST_FSCAN   = 8'b0000_0010,
      ST_SSCAN   = 8'b0000_0100,
      ST_SUPD    = 8'b0000_1000,
      ST_NEWSRC  = 8'b0001_0000,
      ST_SUM     = 8'b0010_0000,
      ST_NEWFLOW = 8'b0100_0000,
      ST_DONE    = 8'b1000_0000
   } state_type;

   state_type             state_ff, state_in;
   logic [KEY_BITS-1:0]   key_ff, key_in;
   logic [ADDR_W-1:0]     addr_ff, addr_in;
   logic [TIME_W-1:0]     now_ff, now_in;
   logic [SCAN_CNT_W-1:0] cnt_ff, cnt_in;
   logic                  pend_ff, pend_in;
   logic [SCAN_IDX_W-1:0] pidx_ff, pidx_in;
   logic                  flow_hit_ff, flow_hit_in;
   logic [FLOW_IDX_W-1:0] flow_sel_ff, flow_sel_in;
   logic                  flow_free_ff, flow_free_in;
   logic [FLOW_IDX_W-1:0] flow_free_idx_ff, flow_free_idx_in;
   logic                  src_hit_ff, src_hit_in;
   logic [SRC_IDX_W-1:0]  src_sel_ff, src_sel_in;
   logic [COUNT_W-1:0]    src_cnt_ff, src_cnt_in;
   logic [TIME_W-1:0]     src_start_ff, src_start_in;
   logic                  src_free_ff, src_free_in;
   logic [SRC_IDX_W-1:0]  src_free_idx_ff, src_free_idx_in;
   logic [SUM_W-1:0]      sum_ff, sum_in;
   out_word_type          res_ff, res_in;
   logic [COUNT_W-1:0]    new_count;

   assign new_count = (src_cnt_ff == COUNT_MAX) ? src_cnt_ff : src_cnt_ff + COUNT_W'(1);
   assign req_stall = (state_ff != ST_IDLE);
   assign res_valid = (state_ff == ST_DONE);
   assign res_word  = res_ff;

   always_comb begin
      state_in         = state_ff;
      key_in           = key_ff;
      addr_in          = addr_ff;
      now_in           = now_ff;
      cnt_in           = cnt_ff;
      pend_in          = 1'b0;
      pidx_in          = pidx_ff;
      flow_hit_in      = flow_hit_ff;
      flow_sel_in      = flow_sel_ff;
      flow_free_in     = flow_free_ff;
      flow_free_idx_in = flow_free_idx_ff;
      src_hit_in       = src_hit_ff;
      src_sel_in       = src_sel_ff;
      src_cnt_in       = src_cnt_ff;
      src_start_in     = src_start_ff;
      src_free_in      = src_free_ff;
      src_free_idx_in  = src_free_idx_ff;
      sum_in           = sum_ff;
      res_in           = res_ff;
      flow_cmd         = '0;
      slot_cmd         = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               key_in       = req_word.flow_key[KEY_BITS-1:0];
               addr_in      = req_word.source_address;
               now_in       = req_word.now_seconds;
               cnt_in       = '0;
               flow_hit_in  = 1'b0;
               flow_free_in = 1'b0;
               src_hit_in   = 1'b0;
               src_free_in  = 1'b0;
               sum_in       = '0;
               res_in       = '0;
               state_in     = ST_FSCAN;
            end
         end

         ST_FSCAN: begin
            if (cnt_ff < SCAN_CNT_W'(MAX_FLOWS)) begin
               flow_cmd.rd_en  = 1'b1;
               flow_cmd.rd_idx = cnt_ff[FLOW_IDX_W-1:0];
               cnt_in          = cnt_ff + SCAN_CNT_W'(1);
               pidx_in         = cnt_ff[SCAN_IDX_W-1:0];
               pend_in         = 1'b1;
            end
            if (pend_ff) begin
               if (flow_rd.used) begin
                  if (!flow_hit_ff && flow_rd.key == key_ff) begin
                     flow_hit_in = 1'b1;
                     flow_sel_in = pidx_ff[FLOW_IDX_W-1:0];
                  end
               end else if (!flow_free_ff) begin
                  flow_free_in     = 1'b1;
                  flow_free_idx_in = pidx_ff[FLOW_IDX_W-1:0];
               end
               // last read word is in
               if (cnt_ff == SCAN_CNT_W'(MAX_FLOWS)) begin
                  cnt_in = '0;
                  if (flow_hit_in) begin
                     state_in = ST_SSCAN;
                  end else if (flow_free_in) begin
                     state_in = ST_NEWFLOW;
                  end else begin
                     res_in.table_full = 1'b1;
                     state_in          = ST_DONE;
                  end
               end
            end
         end

         ST_SSCAN: begin
            if (cnt_ff < SCAN_CNT_W'(SOURCES_PER_FLOW)) begin
               slot_cmd.rd_en  = 1'b1;
               slot_cmd.rd_idx = slot_index(flow_sel_ff, cnt_ff[SRC_IDX_W-1:0]);
               cnt_in          = cnt_ff + SCAN_CNT_W'(1);
               pidx_in         = cnt_ff[SCAN_IDX_W-1:0];
               pend_in         = 1'b1;
            end
            if (pend_ff) begin
               if (slot_rd.used) begin
                  if (!src_hit_ff && slot_rd.entry.address == addr_ff) begin
                     src_hit_in   = 1'b1;
                     src_sel_in   = pidx_ff[SRC_IDX_W-1:0];
                     src_cnt_in   = slot_rd.entry.count;
                     src_start_in = slot_rd.entry.start;
                  end
               end else if (!src_free_ff) begin
                  src_free_in     = 1'b1;
                  src_free_idx_in = pidx_ff[SRC_IDX_W-1:0];
               end
               if (cnt_ff == SCAN_CNT_W'(SOURCES_PER_FLOW)) begin
                  cnt_in = '0;
                  if (src_hit_in) begin
                     state_in = ST_SUPD;
                  end else if (src_free_in) begin
                     state_in = ST_NEWSRC;
                  end else begin
                     res_in.table_full = 1'b1;
                     state_in          = ST_SUM;
                  end
               end
            end
         end

         ST_SUPD: begin
            slot_cmd.wr_en           = 1'b1;
            slot_cmd.wr_idx          = slot_index(flow_sel_ff, src_sel_ff);
            slot_cmd.wr_data.address = addr_ff;
            if (expired(src_start_ff, now_ff, cfg.window_seconds)) begin
               slot_cmd.wr_data.count = COUNT_W'(1);
               slot_cmd.wr_data.start = now_ff;
            end else begin
               slot_cmd.wr_data.count = new_count;
               slot_cmd.wr_data.start = src_start_ff;
               if (new_count > cfg.source_threshold) begin
                  res_in.request_kind    = KIND_SOURCE;
                  res_in.request_address = addr_ff;
               end
            end
            state_in = ST_DONE;
         end

         ST_NEWSRC: begin
            slot_cmd.wr_en           = 1'b1;
            slot_cmd.wr_idx          = slot_index(flow_sel_ff, src_free_idx_ff);
            slot_cmd.wr_data.address = addr_ff;
            slot_cmd.wr_data.count   = '0;
            slot_cmd.wr_data.start   = now_ff;
            slot_cmd.set_used        = 1'b1;
            cnt_in                   = '0;
            state_in                 = ST_SUM;
         end

         ST_SUM: begin
            if (cnt_ff < SCAN_CNT_W'(SOURCES_PER_FLOW)) begin
               slot_cmd.rd_en  = 1'b1;
               slot_cmd.rd_idx = slot_index(flow_sel_ff, cnt_ff[SRC_IDX_W-1:0]);
               cnt_in          = cnt_ff + SCAN_CNT_W'(1);
               pidx_in         = cnt_ff[SCAN_IDX_W-1:0];
               pend_in         = 1'b1;
            end
            if (pend_ff) begin
               if (slot_rd.used) begin
                  // expired windows restart at zero and add nothing
                  if (expired(slot_rd.entry.start, now_ff, cfg.window_seconds)) begin
                     slot_cmd.wr_en           = 1'b1;
                     slot_cmd.wr_idx          = slot_index(flow_sel_ff,
                                                           pidx_ff[SRC_IDX_W-1:0]);
                     slot_cmd.wr_data.address = slot_rd.entry.address;
                     slot_cmd.wr_data.count   = '0;
                     slot_cmd.wr_data.start   = now_ff;
                  end else begin
                     sum_in = sum_ff + SUM_W'(slot_rd.entry.count);
                  end
               end
               if (cnt_ff == SCAN_CNT_W'(SOURCES_PER_FLOW)) begin
                  if (CMP_W'(sum_in) > CMP_W'(cfg.flow_sum_limit)) begin
                     res_in.request_kind = KIND_FLOW;
                  end
                  state_in = ST_DONE;
               end
            end
         end

         ST_NEWFLOW: begin
            flow_cmd.wr_en           = 1'b1;
            flow_cmd.wr_idx          = flow_free_idx_ff;
            flow_cmd.wr_key          = key_ff;
            slot_cmd.init_row        = 1'b1;
            slot_cmd.row             = flow_free_idx_ff;
            slot_cmd.wr_en           = 1'b1;
            slot_cmd.wr_idx          = slot_index(flow_free_idx_ff, '0);
            slot_cmd.wr_data.address = addr_ff;
            slot_cmd.wr_data.count   = COUNT_W'(1);
            slot_cmd.wr_data.start   = now_ff;
            slot_cmd.set_used        = 1'b1;
            state_in                 = ST_DONE;
         end

         ST_DONE: begin
            if (res_ready) begin
               state_in = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         pend_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         pend_ff  <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff           <= key_in;
      addr_ff          <= addr_in;
      now_ff           <= now_in;
      cnt_ff           <= cnt_in;
      pidx_ff          <= pidx_in;
      flow_hit_ff      <= flow_hit_in;
      flow_sel_ff      <= flow_sel_in;
      flow_free_ff     <= flow_free_in;
      flow_free_idx_ff <= flow_free_idx_in;
      src_hit_ff       <= src_hit_in;
      src_sel_ff       <= src_sel_in;
      src_cnt_ff       <= src_cnt_in;
      src_start_ff     <= src_start_in;
      src_free_ff      <= src_free_in;
      src_free_idx_ff  <= src_free_idx_in;
      sum_ff           <= sum_in;
      res_ff           <= res_in;
   end

endmodule

// ===== rtl/core/flow_source_rate_detector.sv =====
// top level of the flow source rate detector: config registers, output register, instances
//
// Usage: each req_ word is one packet event (flow key, source address, time in
// seconds); each event yields exactly one rsp_ word (request kind, address to
// filter, table-full flag). Both channels move a word at an edge where valid is
// high and stall is low. Registers are written through csr_valid/csr_ready with
// csr_index (0 window, 1 source threshold, 2 flow threshold); other indexes are
// ignored. Write them only while no event is in flight.
// Timing: one event at a time. The flow scan reads the flow key memory once per
// flow, the source scan and the sum pass read the slot memory once per source,
// each pass waiting for its last registered read word. A new flow takes the flow
// scan and the new flow write; a known source the flow scan, source scan and slot
// update; a new source the flow scan, source scan, new source write and sum pass.
// A full flow table answers after the flow scan alone. The next event can be
// taken in the cycle after the result moves to the output register.
// Reset clears all used bits and loads the register defaults (10, 100, 500).
// While rsp_stall is high the result holds in the output register; one more
// event may finish behind it, after which req_stall stays high.
module flow_source_rate_detector (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  fsrd_pkg::in_word_type                  req_word,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output fsrd_pkg::out_word_type                 rsp_word,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [fsrd_pkg::CSR_INDEX_W-1:0]       csr_index,
   input  logic [fsrd_pkg::CSR_DATA_W-1:0]        csr_data
);
   import fsrd_pkg::*;

   cfg_type      cfg_ff;
   logic         rsp_valid_ff;
   out_word_type rsp_word_ff;
   logic         res_valid;
   logic         res_ready;
   out_word_type res_word;
   flow_cmd_type flow_cmd;
   flow_rd_type  flow_rd;
   slot_cmd_type slot_cmd;
   slot_rd_type  slot_rd;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.window_seconds   <= WINDOW_RESET;
         cfg_ff.source_threshold <= SOURCE_THR_RESET;
         cfg_ff.flow_sum_limit   <= FLOW_THR_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_WINDOW:     cfg_ff.window_seconds   <= csr_data[WINDOW_W-1:0];
            CSR_SOURCE_THR: cfg_ff.source_threshold <= csr_data[SRC_THR_W-1:0];
            CSR_FLOW_THR:   cfg_ff.flow_sum_limit   <= csr_data[FLOW_THR_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // output register takes a result while it is empty or the receiver does not stall
   assign res_ready = !rsp_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (res_valid && res_ready) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (res_valid && res_ready) begin
         rsp_word_ff <= res_word;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

   fsrd_flow_mem u_flow_mem (
      .clock (clock),
      .reset (reset),
      .cmd   (flow_cmd),
      .rd    (flow_rd)
   );

   fsrd_slot_mem u_slot_mem (
      .clock (clock),
      .reset (reset),
      .cmd   (slot_cmd),
      .rd    (slot_rd)
   );

   fsrd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_word  (req_word),
      .res_valid (res_valid),
      .res_ready (res_ready),
      .res_word  (res_word),
      .flow_cmd  (flow_cmd),
      .flow_rd   (flow_rd),
      .slot_cmd  (slot_cmd),
      .slot_rd   (slot_rd)
   );

endmodule
